// ===== rtl/vic_pkg.sv =====
// Shared types and constants for the vector interrupt controller.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
`timescale 1ns / 1ps

package vic_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned VEC_W       = 8;
  localparam int unsigned CFG_W       = 9;
  localparam int unsigned FIELD_W     = 2;
  localparam int unsigned MAX_VECTORS = 256;

  localparam logic [DATA_W-1:0] HALF_MASK = 64'h0000_0000_ffff_ffff;

  typedef enum logic [FIELD_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SOURCE = 2'd2
  } kind_e;

  typedef enum logic [FIELD_W-1:0] {
    BANK_ENABLE = 2'd0,
    BANK_MODE   = 2'd1,
    BANK_STATUS = 2'd2
  } bank_e;

  typedef enum logic [FIELD_W-1:0] {
    HALF_LOW  = 2'd0,
    HALF_HIGH = 2'd1,
    HALF_FULL = 2'd2
  } half_e;

  // Result of the priority search over the active vectors.
  typedef struct packed {
    logic             found;
    logic [VEC_W-1:0] vector;
  } pend_t;

endpackage

// ===== rtl/vic_ffs.sv =====
// Priority encoder: finds the lowest active vector across all words.
// Depends on vic_pkg for the pend_t result type.
`timescale 1ns / 1ps

module vic_ffs #(
  parameter int unsigned WORDS            = 4,
  parameter int unsigned VECTORS_PER_WORD = 64
) (
  input  logic [WORDS-1:0][VECTORS_PER_WORD-1:0] act_i,
  output vic_pkg::pend_t                         pend_o
);

  localparam int unsigned BIT_W = $clog2(VECTORS_PER_WORD);

  logic [WORDS-1:0]            word_hit;
  logic [WORDS-1:0][BIT_W-1:0] word_bit;

  // Lowest set bit within each word, all words in parallel.
  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      word_hit[w] = |act_i[w];
      word_bit[w] = '0;
      for (int b = VECTORS_PER_WORD - 1; b >= 0; b--) begin
        if (act_i[w][b]) begin
          word_bit[w] = BIT_W'(b);
        end
      end
    end
  end

  // The lowest word with any active bit wins.
  always_comb begin
    pend_o = '0;
    for (int w = WORDS - 1; w >= 0; w--) begin
      if (word_hit[w]) begin
        pend_o.found  = 1'b1;
        pend_o.vector = vic_pkg::VEC_W'(w * VECTORS_PER_WORD + int'(word_bit[w]));
      end
    end
  end

endmodule

// ===== rtl/vector_interrupt_controller.sv =====
// Vector interrupt controller top level: request register, bank state, result register.
// Depends on vic_pkg and instantiates vic_ffs.
`timescale 1ns / 1ps

// Usage
// A request is presented on kind_i and the payload ports and is taken at a rising edge
// with start_i high and busy_o low. busy_o is always low: the block takes one request
// in every cycle. A request is a bus read or write of one enable, mode or status word
// (or a 32-bit half of it), or a level change on one interrupt source.
// Each request produces exactly one result, shown for one cycle with done_o high. The
// result carries the data read (zero for anything but a read), the interrupt line and
// the lowest vector that is both pending and enabled, as seen after the request.
// A request passes through the request register, the bank update (which also latches
// the read data) and the result register behind the priority encoder. Throughput is
// one request per cycle, with no stall anywhere in the pipeline.
// The receiver cannot hold results off; done_o is a pure strobe. The user must write
// vectors_in_use via cfg_we_i/cfg_wdata_i while no request is in flight; not enforced.
// Reset (rst_ni low, asynchronous) clears all four banks and any request in flight, and
// sets vectors_in_use to 256, so every vector is served.
module vector_interrupt_controller #(
  parameter int unsigned WORDS            = 4,
  parameter int unsigned VECTORS_PER_WORD = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [vic_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [vic_pkg::FIELD_W-1:0]   kind_i,
  input  logic [vic_pkg::FIELD_W-1:0]   bank_i,
  input  logic [vic_pkg::FIELD_W-1:0]   word_index_i,
  input  logic [vic_pkg::FIELD_W-1:0]   half_select_i,
  input  logic [vic_pkg::DATA_W-1:0]    write_data_i,
  input  logic [vic_pkg::VEC_W-1:0]     vector_i,
  input  logic                          level_i,
  output logic                          done_o,
  output logic [vic_pkg::DATA_W-1:0]    read_data_o,
  output logic                          irq_line_o,
  output logic [vic_pkg::VEC_W-1:0]     first_pending_o,
  output logic                          first_valid_o
);

  localparam int unsigned VPW       = VECTORS_PER_WORD;
  localparam int unsigned TOTAL     = WORDS * VPW;
  localparam int unsigned SERVE_MAX =
      (TOTAL < vic_pkg::MAX_VECTORS) ? TOTAL : vic_pkg::MAX_VECTORS;

  typedef logic [WORDS-1:0][VPW-1:0] bank_t;

  // Configuration.
  logic [vic_pkg::CFG_W-1:0] cfg_q;
  logic [vic_pkg::CFG_W-1:0] served_n;
  bank_t                     served;

  // Request register.
  logic                          s1_valid_q;
  vic_pkg::kind_e                kind_q;
  vic_pkg::bank_e                bank_q;
  logic [vic_pkg::FIELD_W-1:0]   widx_q;
  vic_pkg::half_e                half_q;
  logic [vic_pkg::DATA_W-1:0]    wdata_q;
  logic [vic_pkg::VEC_W-1:0]     vec_q;
  logic                          lvl_q;

  // Bank state.
  bank_t en_q, en_d, mode_q, mode_d, stat_q, stat_d, src_q, src_d;
  logic                       s2_valid_q;
  logic [vic_pkg::DATA_W-1:0] rd_q, rd_d;

  // Result register.
  logic                       done_q;
  logic [vic_pkg::DATA_W-1:0] read_data_q;
  logic                       irq_q;
  logic [vic_pkg::VEC_W-1:0]  first_q;
  vic_pkg::pend_t             pend;
  bank_t                      act;

  logic [vic_pkg::DATA_W-1:0] cur_word;
  logic [vic_pkg::DATA_W-1:0] sel, val;
  logic                       word_ok;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vic_pkg::CFG_W'(vic_pkg::MAX_VECTORS);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // The served count is capped at the number of vectors that are actually stored.
  assign served_n = (int'(cfg_q) > SERVE_MAX) ? vic_pkg::CFG_W'(SERVE_MAX) : cfg_q;

  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      for (int b = 0; b < VPW; b++) begin
        served[w][b] = (w * VPW + b) < int'(served_n);
      end
    end
  end

  // Request register: control cleared by reset, payload not reset and loaded when a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      kind_q  <= vic_pkg::kind_e'(kind_i);
      bank_q  <= vic_pkg::bank_e'(bank_i);
      widx_q  <= word_index_i;
      half_q  <= vic_pkg::half_e'(half_select_i);
      wdata_q <= write_data_i;
      vec_q   <= vector_i;
      lvl_q   <= level_i;
    end
  end

  assign word_ok = int'(widx_q) < WORDS;

  // Addressed word of the selected bank, zero-extended to the bus width.
  always_comb begin
    cur_word = '0;
    for (int w = 0; w < WORDS; w++) begin
      if (int'(widx_q) == w) begin
        case (bank_q)
          vic_pkg::BANK_ENABLE: cur_word = vic_pkg::DATA_W'(en_q[w]);
          vic_pkg::BANK_MODE:   cur_word = vic_pkg::DATA_W'(mode_q[w]);
          vic_pkg::BANK_STATUS: cur_word = vic_pkg::DATA_W'(stat_q[w]);
          default:              cur_word = '0;
        endcase
      end
    end
  end

  // Read data is taken from the state before this request's update.
  always_comb begin
    rd_d = '0;
    if (kind_q == vic_pkg::KIND_READ && word_ok) begin
      case (half_q)
        vic_pkg::HALF_LOW:  rd_d = cur_word & vic_pkg::HALF_MASK;
        vic_pkg::HALF_HIGH: rd_d = (cur_word >> vic_pkg::HALF_W) & vic_pkg::HALF_MASK;
        vic_pkg::HALF_FULL: rd_d = cur_word;
        default:            rd_d = '0;
      endcase
    end
  end

  // Lane select and data of a write; an unused half code selects nothing.
  always_comb begin
    case (half_q)
      vic_pkg::HALF_LOW: begin
        sel = vic_pkg::HALF_MASK;
        val = wdata_q & vic_pkg::HALF_MASK;
      end
      vic_pkg::HALF_HIGH: begin
        sel = vic_pkg::HALF_MASK << vic_pkg::HALF_W;
        val = (wdata_q & vic_pkg::HALF_MASK) << vic_pkg::HALF_W;
      end
      vic_pkg::HALF_FULL: begin
        sel = '1;
        val = wdata_q;
      end
      default: begin
        sel = '0;
        val = '0;
      end
    endcase
    val = val & sel;
  end

  // Bank update: access or source event first, then level-mode sources set status.
  always_comb begin
    en_d   = en_q;
    mode_d = mode_q;
    stat_d = stat_q;
    src_d  = src_q;
    if (s1_valid_q) begin
      for (int w = 0; w < WORDS; w++) begin
        if (kind_q == vic_pkg::KIND_WRITE && word_ok && int'(widx_q) == w) begin
          case (bank_q)
            vic_pkg::BANK_ENABLE:
              en_d[w] = (en_q[w] & ~sel[VPW-1:0]) | val[VPW-1:0];
            vic_pkg::BANK_MODE:
              mode_d[w] = (mode_q[w] & ~sel[VPW-1:0]) | val[VPW-1:0];
            vic_pkg::BANK_STATUS:
              stat_d[w] = stat_q[w] & ~val[VPW-1:0];
            default: ;
          endcase
        end
        for (int b = 0; b < VPW; b++) begin
          if (kind_q == vic_pkg::KIND_SOURCE && served[w][b] &&
              int'(vec_q) == w * VPW + b) begin
            if (lvl_q) begin
              // A rising edge on an edge-mode source latches status.
              if (!src_q[w][b] && !mode_q[w][b]) begin
                stat_d[w][b] = 1'b1;
              end
              src_d[w][b] = 1'b1;
            end else begin
              src_d[w][b] = 1'b0;
            end
          end
        end
        stat_d[w] = stat_d[w] | (mode_d[w] & src_d[w] & served[w]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= '0;
      mode_q     <= '0;
      stat_q     <= '0;
      src_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      en_q       <= en_d;
      mode_q     <= mode_d;
      stat_q     <= stat_d;
      src_q      <= src_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      rd_q <= rd_d;
    end
  end

  // Priority search over the updated banks.
  assign act = stat_q & en_q & served;

  vic_ffs #(
    .WORDS            (WORDS),
    .VECTORS_PER_WORD (VPW)
  ) u_ffs (
    .act_i  (act),
    .pend_o (pend)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      read_data_q <= rd_q;
      irq_q       <= pend.found;
      first_q     <= pend.vector;
    end
  end

  assign done_o          = done_q;
  assign read_data_o     = read_data_q;
  assign irq_line_o      = irq_q;
  assign first_pending_o = first_q;
  assign first_valid_o   = irq_q;

endmodule

// ===== rtl/vic_checker.sv =====
// Port-level checker for the vector interrupt controller, bound to the top level.
// Depends on vic_pkg for the request kind and half codes.
`timescale 1ns / 1ps

module vic_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [vic_pkg::FIELD_W-1:0] kind_i,
  input logic [vic_pkg::FIELD_W-1:0] half_select_i,
  input logic                        done_o,
  input logic [vic_pkg::DATA_W-1:0]  read_data_o,
  input logic                        irq_line_o,
  input logic [vic_pkg::VEC_W-1:0]   first_pending_o,
  input logic                        first_valid_o
);

  // Every accepted request yields its result after the request, bank and result registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("accepted request produced no result");

  // No result appears without a matching accepted request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result without a matching request");

  // The valid flag and the interrupt line agree, and no vector means vector zero.
  a_pending_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (first_valid_o == irq_line_o) && (first_valid_o || first_pending_o == '0))
    else $error("pending vector inconsistent with interrupt line");

  // Anything but a read returns zero data.
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(kind_i, 3) != vic_pkg::KIND_READ) |-> read_data_o == '0)
    else $error("non-read request returned data");

  // A half read only fills the low half.
  a_half_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(half_select_i, 3) != vic_pkg::HALF_FULL)
      |-> read_data_o[vic_pkg::DATA_W-1:vic_pkg::HALF_W] == '0)
    else $error("half read returned upper bits");

endmodule

bind vector_interrupt_controller vic_checker u_vic_checker (.*);

// ===== dv/vic_checker.sv =====
// Scoreboard for the vector interrupt controller: tracks the four banks and the served count.
// Depends on vic_pkg; watches the request, configuration and result ports of the block.
`timescale 1ns / 1ps

module vic_scoreboard (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        cfg_we_i,
  input  logic [vic_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [vic_pkg::FIELD_W-1:0] kind_i,
  input  logic [vic_pkg::FIELD_W-1:0] bank_i,
  input  logic [vic_pkg::FIELD_W-1:0] word_index_i,
  input  logic [vic_pkg::FIELD_W-1:0] half_select_i,
  input  logic [vic_pkg::DATA_W-1:0]  write_data_i,
  input  logic [vic_pkg::VEC_W-1:0]   vector_i,
  input  logic                        level_i,
  input  logic                        done_i,
  input  logic [vic_pkg::DATA_W-1:0]  read_data_i,
  input  logic                        irq_line_i,
  input  logic [vic_pkg::VEC_W-1:0]   first_pending_i,
  input  logic                        first_valid_i,
  output int unsigned                 reports_waiting_o,
  output int unsigned                 reports_checked_o,
  output int unsigned                 fail_count_o
);

  import vic_pkg::*;

  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned WORD_BITS = 64;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_line;
    logic [VEC_W-1:0]  first_pending;
    logic              first_valid;
  } irq_report_t;

  logic [DATA_W-1:0] enable_q [NUM_WORDS];
  logic [DATA_W-1:0] mode_q   [NUM_WORDS];
  logic [DATA_W-1:0] status_q [NUM_WORDS];
  logic [DATA_W-1:0] source_q [NUM_WORDS];
  logic [CFG_W-1:0]  served_cfg;
  irq_report_t       irq_reports_q [$];
  int unsigned       mismatches;
  int unsigned       checked;

  // Vectors of word w that are below the served count.
  function automatic logic [DATA_W-1:0] served_bits(input int unsigned w, input int unsigned n);
    int unsigned base;
    base = w * WORD_BITS;
    if (n <= base) return '0;
    if (n - base >= WORD_BITS) return '1;
    return (64'd1 << (n - base)) - 64'd1;
  endfunction

  // Applies one request to the tracked banks and forms the report it should produce.
  function automatic irq_report_t apply_request(
    input logic [FIELD_W-1:0] kind, input logic [FIELD_W-1:0] bank,
    input logic [FIELD_W-1:0] word, input logic [FIELD_W-1:0] half,
    input logic [DATA_W-1:0] data, input logic [VEC_W-1:0] vec, input logic lvl
  );
    irq_report_t       rep;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] sel;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] act;
    logic              bank_ok;
    int unsigned       served;
    int unsigned       w;
    int unsigned       b;
    rep = '0;
    served = 32'(served_cfg);
    if (served > MAX_VECTORS) served = MAX_VECTORS;
    bank_ok = 1'b1;
    case (bank)
      BANK_ENABLE: cur = enable_q[word];
      BANK_MODE:   cur = mode_q[word];
      BANK_STATUS: cur = status_q[word];
      default: begin
        cur = '0;
        bank_ok = 1'b0;
      end
    endcase

    if (kind == KIND_READ && bank_ok) begin
      case (half)
        HALF_LOW:  rep.read_data = cur & HALF_MASK;
        HALF_HIGH: rep.read_data = (cur >> HALF_W) & HALF_MASK;
        HALF_FULL: rep.read_data = cur;
        default:   rep.read_data = '0;
      endcase
    end else if (kind == KIND_WRITE && bank_ok && half inside {HALF_LOW, HALF_HIGH, HALF_FULL}) begin
      case (half)
        HALF_LOW: begin
          sel = HALF_MASK;
          val = data & HALF_MASK;
        end
        HALF_HIGH: begin
          sel = HALF_MASK << HALF_W;
          val = (data & HALF_MASK) << HALF_W;
        end
        default: begin
          sel = '1;
          val = data;
        end
      endcase
      case (bank)
        BANK_ENABLE: enable_q[word] = (cur & ~sel) | val;
        BANK_MODE:   mode_q[word]   = (cur & ~sel) | val;
        default:     status_q[word] = cur & ~val;
      endcase
    end else if (kind == KIND_SOURCE && 32'(vec) < served) begin
      w = 32'(vec) / WORD_BITS;
      b = 32'(vec) % WORD_BITS;
      if (lvl) begin
        // Edge mode sets the status bit only on a rising level.
        if (!source_q[w][b] && !mode_q[w][b]) status_q[w][b] = 1'b1;
        source_q[w][b] = 1'b1;
      end else begin
        source_q[w][b] = 1'b0;
      end
    end

    for (int i = 0; i < NUM_WORDS; i++)
      status_q[i] |= mode_q[i] & source_q[i] & served_bits(i, served);

    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      act = status_q[i] & enable_q[i] & served_bits(i, served);
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
        if (act[j]) begin
          rep.irq_line      = 1'b1;
          rep.first_valid   = 1'b1;
          rep.first_pending = VEC_W'(i * WORD_BITS + j);
        end
      end
    end
    return rep;
  endfunction

  always @(posedge clk_i) begin
    irq_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        enable_q[i] = '0;
        mode_q[i]   = '0;
        status_q[i] = '0;
        source_q[i] = '0;
      end
      served_cfg = CFG_W'(MAX_VECTORS);
      irq_reports_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) served_cfg = cfg_wdata_i;
      if (done_i) begin
        if (irq_reports_q.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatches++;
        end else begin
          want = irq_reports_q.pop_front();
          checked++;
          if (read_data_i !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, read_data_i);
            mismatches++;
          end
          if (irq_line_i !== want.irq_line) begin
            $error("irq_line: expected %b, actual %b", want.irq_line, irq_line_i);
            mismatches++;
          end
          if (first_pending_i !== want.first_pending) begin
            $error("first_pending: expected %0d, actual %0d", want.first_pending,
                   first_pending_i);
            mismatches++;
          end
          if (first_valid_i !== want.first_valid) begin
            $error("first_valid: expected %b, actual %b", want.first_valid, first_valid_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i)
        irq_reports_q.push_back(apply_request(kind_i, bank_i, word_index_i, half_select_i,
                                              write_data_i, vector_i, level_i));
    end
    reports_waiting_o <= 32'(irq_reports_q.size());
    reports_checked_o <= checked;
    fail_count_o      <= mismatches;
  end

endmodule

// ===== dv/vector_interrupt_controller_tb.sv =====
// Top of the vector interrupt controller testbench: clock, reset, request stimulus and verdict.
// Depends on vic_pkg, the block under test and vic_scoreboard, which predicts and compares every result.
`timescale 1ns / 1ps

module vector_interrupt_controller_tb;

  import vic_pkg::*;

  // Code 3 is left unused in the kind, bank and half fields; the block must ignore it.
  localparam logic [FIELD_W-1:0] FIELD_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0]  ALL_ONES     = {DATA_W{1'b1}};
  // Longest stretch without any accepted request or result. The slowest correct run
  // sees at most the longest sender gap plus the pipeline, or a drain and a configuration
  // write, so this is many times the worst case.
  localparam int unsigned        STALL_LIMIT  = 2000;
  localparam int unsigned        PHASES       = 10;
  localparam int unsigned        PHASE_ITEMS  = 93;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic [FIELD_W-1:0]  kind_i;
  logic [FIELD_W-1:0]  bank_i;
  logic [FIELD_W-1:0]  word_index_i;
  logic [FIELD_W-1:0]  half_select_i;
  logic [DATA_W-1:0]   write_data_i;
  logic [VEC_W-1:0]    vector_i;
  logic                level_i;
  logic                done_o;
  logic [DATA_W-1:0]   read_data_o;
  logic                irq_line_o;
  logic [VEC_W-1:0]    first_pending_o;
  logic                first_valid_o;

  int unsigned         reports_waiting;
  int unsigned         reports_checked;
  int unsigned         fail_count;
  int unsigned         stall_cycles;
  int unsigned         requests_sent;
  int unsigned         served_now;
  logic                gaps_on;

  vector_interrupt_controller uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .bank_i         (bank_i),
    .word_index_i   (word_index_i),
    .half_select_i  (half_select_i),
    .write_data_i   (write_data_i),
    .vector_i       (vector_i),
    .level_i        (level_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .irq_line_o     (irq_line_o),
    .first_pending_o(first_pending_o),
    .first_valid_o  (first_valid_o)
  );

  // The scoreboard sees exactly what the block sees and does all prediction and comparison.
  vic_scoreboard u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .bank_i           (bank_i),
    .word_index_i     (word_index_i),
    .half_select_i    (half_select_i),
    .write_data_i     (write_data_i),
    .vector_i         (vector_i),
    .level_i          (level_i),
    .done_i           (done_o),
    .read_data_i      (read_data_o),
    .irq_line_i       (irq_line_o),
    .first_pending_i  (first_pending_o),
    .first_valid_i    (first_valid_o),
    .reports_waiting_o(reports_waiting),
    .reports_checked_o(reports_checked),
    .fail_count_o     (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Counts cycles in which neither a request nor a result is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Presents one request and holds it until the block takes it. start_i is left high
  // afterwards, so back-to-back requests need no idle gap; whoever idles next lowers it.
  task automatic drive_request(
    input logic [FIELD_W-1:0] kind, input logic [FIELD_W-1:0] bank,
    input logic [FIELD_W-1:0] word, input logic [FIELD_W-1:0] half,
    input logic [DATA_W-1:0] data, input logic [VEC_W-1:0] vec, input logic lvl
  );
    start_i       <= 1'b1;
    kind_i        <= kind;
    bank_i        <= bank;
    word_index_i  <= word;
    half_select_i <= half;
    write_data_i  <= data;
    vector_i      <= vec;
    level_i       <= lvl;
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
  endtask

  // Random sender gap before the next request: mostly none, otherwise short or, now and
  // then, long, so gaps land on every stage of the pipeline.
  task automatic sender_gap();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 55) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every outstanding request has produced its result.
  task automatic drain_requests();
    start_i <= 1'b0;
    do @(posedge clk_i); while (reports_waiting != 0);
  endtask

  // vectors_in_use may only change while nothing is in flight, hence the drain first.
  task automatic set_served(input logic [CFG_W-1:0] count);
    drain_requests();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    served_now  = 32'(count);
  endtask

  // Mostly well-formed bank accesses and source changes, with vectors biased into the
  // served range so that status, enable and priority interact; a few requests carry the
  // unused codes.
  task automatic random_request();
    logic [FIELD_W-1:0] kind;
    logic [FIELD_W-1:0] bank;
    logic [FIELD_W-1:0] word;
    logic [FIELD_W-1:0] half;
    logic [DATA_W-1:0]  data;
    logic [VEC_W-1:0]   vec;
    logic               lvl;
    int unsigned        roll;
    int unsigned        limit;
    roll  = $urandom_range(0, 99);
    bank  = FIELD_W'($urandom_range(0, 2));
    word  = FIELD_W'($urandom_range(0, 3));
    half  = FIELD_W'($urandom_range(0, 2));
    data  = {$urandom, $urandom};
    lvl   = 1'($urandom_range(0, 1));
    limit = (served_now > MAX_VECTORS) ? MAX_VECTORS : served_now;
    if (limit != 0 && $urandom_range(0, 3) != 0) vec = VEC_W'($urandom_range(0, limit - 1));
    else vec = VEC_W'($urandom_range(0, 255));
    if (roll < 40) kind = KIND_SOURCE;
    else if (roll < 65) kind = KIND_WRITE;
    else if (roll < 95) kind = KIND_READ;
    else begin
      kind = FIELD_W'($urandom_range(0, 3));
      bank = FIELD_W'($urandom_range(0, 3));
      half = FIELD_W'($urandom_range(0, 3));
    end
    drive_request(kind, bank, word, half, data, vec, lvl);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_served [PHASES];
    phase_served = '{9'd256, 9'd1, 9'd64, 9'd511, 9'd130, 9'd0, 9'd255, 9'd65, 9'd0, 9'd256};
    phase_served[8] = CFG_W'($urandom_range(0, 511));
    requests_sent = 0;
    served_now    = MAX_VECTORS;
    gaps_on       = 1'b0;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    kind_i        <= KIND_READ;
    bank_i        <= BANK_ENABLE;
    word_index_i  <= '0;
    half_select_i <= HALF_LOW;
    write_data_i  <= '0;
    vector_i      <= '0;
    level_i       <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_served(9'd256);

    // Directed part, back to back. First the enable bank and an edge-mode source:
    // a rising level sets status, a level held high does not set it again, and a
    // write of one to the status bank clears it.
    drive_request(KIND_READ,   BANK_ENABLE, 2'd0, HALF_FULL, '0,       8'd0, 1'b0);
    drive_request(KIND_WRITE,  BANK_ENABLE, 2'd0, HALF_FULL, ALL_ONES, 8'd0, 1'b0);
    drive_request(KIND_WRITE,  BANK_ENABLE, 2'd3, HALF_HIGH, ALL_ONES, 8'd0, 1'b0);
    drive_request(KIND_SOURCE, BANK_ENABLE, 2'd0, HALF_LOW,  '0,       8'd0, 1'b1);
    drive_request(KIND_READ,   BANK_STATUS, 2'd0, HALF_FULL, '0,       8'd0, 1'b0);
    drive_request(KIND_SOURCE, BANK_ENABLE, 2'd0, HALF_LOW,  '0,       8'd0, 1'b1);
    drive_request(KIND_WRITE,  BANK_STATUS, 2'd0, HALF_LOW,  64'h1,    8'd0, 1'b0);
    // Level mode on the top vector: status follows the held level, is set again in
    // the same request when cleared while the level is still high, and survives the
    // falling level until it is cleared by a write.
    drive_request(KIND_WRITE,  BANK_MODE,   2'd3, HALF_FULL, 64'h8000_0000_0000_0000, 8'd0,
                  1'b0);
    drive_request(KIND_SOURCE, BANK_ENABLE, 2'd0, HALF_LOW,  '0,       8'd255, 1'b1);
    drive_request(KIND_WRITE,  BANK_STATUS, 2'd3, HALF_FULL, ALL_ONES, 8'd0,   1'b0);
    drive_request(KIND_SOURCE, BANK_ENABLE, 2'd0, HALF_LOW,  '0,       8'd255, 1'b0);
    drive_request(KIND_READ,   BANK_STATUS, 2'd3, HALF_HIGH, '0,       8'd0,   1'b0);
    drive_request(KIND_WRITE,  BANK_STATUS, 2'd3, HALF_HIGH, 64'h8000_0000, 8'd0, 1'b0);
    // A half write takes only the low 32 bits of the data.
    drive_request(KIND_WRITE,  BANK_ENABLE, 2'd1, HALF_LOW,  64'hdead_beef_1234_5678, 8'd0,
                  1'b0);
    drive_request(KIND_READ,   BANK_ENABLE, 2'd1, HALF_FULL, '0,       8'd0,   1'b0);
    drive_request(KIND_READ,   BANK_ENABLE, 2'd3, HALF_LOW,  '0,       8'd0,   1'b0);
    drive_request(KIND_WRITE,  BANK_MODE,   2'd2, HALF_FULL, ALL_ONES, 8'd0,   1'b0);
    drive_request(KIND_SOURCE, BANK_ENABLE, 2'd0, HALF_LOW,  '0,       8'd128, 1'b1);
    // Unused kind, bank and half codes read as zero and leave the banks alone.
    drive_request(FIELD_UNUSED, BANK_ENABLE, 2'd0, HALF_FULL, ALL_ONES, 8'd7, 1'b1);
    drive_request(KIND_READ,   FIELD_UNUSED, 2'd0, HALF_FULL, '0,       8'd0, 1'b0);
    drive_request(KIND_WRITE,  FIELD_UNUSED, 2'd0, HALF_FULL, ALL_ONES, 8'd0, 1'b0);
    drive_request(KIND_READ,   BANK_MODE,    2'd2, FIELD_UNUSED, '0,    8'd0, 1'b0);
    drive_request(KIND_WRITE,  BANK_MODE,    2'd2, FIELD_UNUSED, '0,    8'd0, 1'b0);
    drive_request(KIND_READ,   BANK_MODE,    2'd2, HALF_FULL, '0,       8'd0, 1'b0);
    // With no vector served nothing is pending, whatever the status bank holds, and
    // source changes are ignored; widening the range brings vector 128 back.
    set_served(9'd0);
    drive_request(KIND_SOURCE, BANK_ENABLE, 2'd0, HALF_LOW,  '0, 8'd5,   1'b1);
    drive_request(KIND_READ,   BANK_STATUS, 2'd0, HALF_FULL, '0, 8'd0,   1'b0);
    set_served(9'd129);
    drive_request(KIND_READ,   BANK_STATUS, 2'd2, HALF_FULL, '0, 8'd0,   1'b0);
    drive_request(KIND_SOURCE, BANK_ENABLE, 2'd0, HALF_LOW,  '0, 8'd200, 1'b1);

    // Random part: one served count per phase, including both extremes and a value
    // above the vector total. Some phases run without any sender gaps.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_served(phase_served[ph]);
      gaps_on = (ph % 4 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 199) == 0) drain_requests();
        sender_gap();
        random_request();
      end
    end

    drain_requests();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d requests (directed and random) over %0d served-count settings,",
             requests_sent, PHASES + 3);
    $display("including zero, 256 and 511; %0d results were checked.", reports_checked);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
